// ----- hw/rtl/tsrr_pkg.sv -----
`timescale 1ns / 1ps

package tsrr_pkg;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_SLEEP = 2'd1,
    SLOT_RUN   = 2'd2
  } slot_state_e;

  typedef enum logic {
    CMD_SPAWN = 1'b0,
    CMD_SCHED = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SPAWN_SCAN,
    FSM_SCHED_SAVE,
    FSM_SCHED_SCAN,
    FSM_SCHED_FETCH,
    FSM_DONE
  } fsm_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam int unsigned PcW   = 64;
  localparam int unsigned TaskW = 3;

  // table access control: optional write, and the state the probe looks for
  typedef struct packed {
    logic        we;
    slot_state_e wstate;
    slot_state_e want;
  } tbl_ctrl_t;

endpackage

// ----- hw/rtl/task_slot_round_robin_scheduler.sv -----
// Spawn probes the slot table for an empty slot, one slot probed per cycle; schedule
//   saves the current task, probes round-robin for a sleeping slot and fetches its address.
// One command at a time: a new command is taken only while idle, once the last
//   result has moved into the output register.
// A finished result waits in the output register while the next command runs.
// Reset (async, active low): all slots empty, current slot 0, no result pending.
`timescale 1ns / 1ps

module task_slot_round_robin_scheduler #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [63:0] entry_pc_i,
  input  logic [63:0] trap_pc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [2:0]  task_index_o,
  output logic [63:0] resume_pc_o
);

  localparam int unsigned IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned ExtW = IdxW + tsrr_pkg::TaskW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TASK_SLOTS - 1);

  tsrr_pkg::fsm_e state_q, state_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [IdxW-1:0] cur_q, cur_d;
  tsrr_pkg::cmd_e  cmd_q, cmd_d;
  logic [tsrr_pkg::PcW-1:0] pc_q, pc_d;

  logic                       res_status_q, res_status_d;
  logic [tsrr_pkg::TaskW-1:0] res_idx_q, res_idx_d;
  logic [tsrr_pkg::PcW-1:0]   res_pc_q, res_pc_d;

  logic                       out_valid_q, out_valid_d;
  logic                       out_status_q, out_status_d;
  logic [tsrr_pkg::TaskW-1:0] out_idx_q, out_idx_d;
  logic [tsrr_pkg::PcW-1:0]   out_pc_q, out_pc_d;

  logic [IdxW-1:0]          tbl_idx;
  tsrr_pkg::tbl_ctrl_t      tbl_ctrl;
  logic                     tbl_match;
  logic                     ram_we;
  logic [IdxW-1:0]          ram_addr;
  logic [tsrr_pkg::PcW-1:0] ram_rdata;

  logic [IdxW-1:0] ptr_next;
  logic [ExtW-1:0] ptr_ext;
  logic            in_beat;
  logic            out_free;

  // input is taken only while idle, so the stall is known from the state alone
  assign in_beat  = in_valid_i && (state_q == tsrr_pkg::FSM_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ptr_next = (ptr_q == LastIdx) ? '0 : ptr_q + IdxW'(1);
  assign ptr_ext  = ExtW'(ptr_q);

  tsrr_slot_table #(
    .TASK_SLOTS(TASK_SLOTS),
    .IdxW      (IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (tbl_idx),
    .ctrl_i (tbl_ctrl),
    .match_o(tbl_match)
  );

  tsrr_ram #(
    .Width(tsrr_pkg::PcW),
    .Depth(1 << IdxW)
  ) u_pc_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(pc_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsrr_pkg::FSM_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    cmd_q        <= cmd_d;
    pc_q         <= pc_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_pc_q     <= res_pc_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_pc_q     <= out_pc_d;
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    cur_d        = cur_q;
    cmd_d        = cmd_q;
    pc_d         = pc_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_pc_d     = res_pc_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_pc_d     = out_pc_q;
    tbl_idx         = ptr_q;
    tbl_ctrl.we     = 1'b0;
    tbl_ctrl.wstate = tsrr_pkg::SLOT_SLEEP;
    tbl_ctrl.want   = tsrr_pkg::SLOT_EMPTY;
    ram_we          = 1'b0;
    ram_addr        = ptr_q;
    in_stall_o      = 1'b1;

    unique case (state_q)
      tsrr_pkg::FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_beat) begin
          cmd_d = tsrr_pkg::cmd_e'(cmd_i);
          ptr_d = '0;
          if (cmd_i == tsrr_pkg::CMD_SCHED) begin
            pc_d    = trap_pc_i;
            state_d = tsrr_pkg::FSM_SCHED_SAVE;
          end else begin
            pc_d    = entry_pc_i;
            state_d = tsrr_pkg::FSM_SPAWN_SCAN;
          end
        end
      end
      tsrr_pkg::FSM_SPAWN_SCAN: begin
        tbl_ctrl.want   = tsrr_pkg::SLOT_EMPTY;
        tbl_ctrl.wstate = tsrr_pkg::SLOT_SLEEP;
        if (tbl_match) begin
          tbl_ctrl.we  = 1'b1;
          ram_we       = 1'b1;
          res_status_d = tsrr_pkg::STATUS_OK;
          res_idx_d    = ptr_ext[tsrr_pkg::TaskW-1:0];
          res_pc_d     = '0;
          state_d      = tsrr_pkg::FSM_DONE;
        end else if (ptr_q == LastIdx) begin
          res_status_d = tsrr_pkg::STATUS_FULL;
          res_idx_d    = '0;
          res_pc_d     = '0;
          state_d      = tsrr_pkg::FSM_DONE;
        end else begin
          ptr_d = ptr_next;
        end
      end
      tsrr_pkg::FSM_SCHED_SAVE: begin
        // park the current task, even if its slot was empty
        tbl_idx         = cur_q;
        tbl_ctrl.we     = 1'b1;
        tbl_ctrl.wstate = tsrr_pkg::SLOT_SLEEP;
        ram_addr        = cur_q;
        ram_we          = 1'b1;
        ptr_d           = (cur_q == LastIdx) ? '0 : cur_q + IdxW'(1);
        state_d         = tsrr_pkg::FSM_SCHED_SCAN;
      end
      tsrr_pkg::FSM_SCHED_SCAN: begin
        // ends at the latest back at the current slot, now sleeping
        tbl_ctrl.want   = tsrr_pkg::SLOT_SLEEP;
        tbl_ctrl.wstate = tsrr_pkg::SLOT_RUN;
        if (tbl_match) begin
          tbl_ctrl.we  = 1'b1;
          cur_d        = ptr_q;
          res_status_d = tsrr_pkg::STATUS_OK;
          res_idx_d    = ptr_ext[tsrr_pkg::TaskW-1:0];
          state_d      = tsrr_pkg::FSM_SCHED_FETCH;
        end else begin
          ptr_d = ptr_next;
        end
      end
      tsrr_pkg::FSM_SCHED_FETCH: begin
        res_pc_d = ram_rdata;
        state_d  = tsrr_pkg::FSM_DONE;
      end
      tsrr_pkg::FSM_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = res_idx_q;
          out_pc_d     = res_pc_q;
          state_d      = tsrr_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = tsrr_pkg::FSM_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign task_index_o = out_idx_q;
  assign resume_pc_o  = out_pc_q;

  // a full-table spawn reports slot zero and no address
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tsrr_pkg::STATUS_FULL) |->
      (task_index_o == '0) && (resume_pc_o == '0))
    else $error("full spawn result carries nonzero fields");

  // schedule never reports failure
  a_sched_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsrr_pkg::FSM_DONE) && (cmd_q == tsrr_pkg::CMD_SCHED) |->
      (res_status_q == tsrr_pkg::STATUS_OK))
    else $error("schedule produced failure status");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tsrr_pkg::FSM_SPAWN_SCAN) || (state_q == tsrr_pkg::FSM_SCHED_SCAN)) |->
      (ptr_q <= LastIdx))
    else $error("scan pointer out of range");

  // a found schedule target becomes current on the next edge
  a_cur_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsrr_pkg::FSM_SCHED_SCAN) && tbl_match |=>
      (cur_q == $past(ptr_q)) && (state_q == tsrr_pkg::FSM_SCHED_FETCH))
    else $error("current slot not updated after schedule");

endmodule

// ----- hw/rtl/tsrr_ram.sv -----
`timescale 1ns / 1ps

module tsrr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tsrr_slot_table.sv -----
`timescale 1ns / 1ps

// Slot state flops with one probe port: read, compare against a wanted state,
// and optionally overwrite the probed slot in the same cycle.
module tsrr_slot_table #(
  parameter int unsigned TASK_SLOTS = 8,
  parameter int unsigned IdxW       = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IdxW-1:0]     idx_i,
  input  tsrr_pkg::tbl_ctrl_t ctrl_i,
  output logic                match_o
);

  tsrr_pkg::slot_state_e state_q [TASK_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        state_q[i] <= tsrr_pkg::SLOT_EMPTY;
      end
    end else if (ctrl_i.we) begin
      state_q[idx_i] <= ctrl_i.wstate;
    end
  end

  assign match_o = (state_q[idx_i] == ctrl_i.want);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TASK_SLOTS   = 8;
  localparam int unsigned RANDOM_CMDS  = 1030;
  localparam int unsigned CALM_TAIL    = 150;   // last commands run with no idling
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 240;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned SHOW_MAX     = 10;

  typedef struct packed {
    logic                       status;
    logic [tsrr_pkg::TaskW-1:0] idx;
    logic [tsrr_pkg::PcW-1:0]   pc;
  } sched_result_t;

  // Shadow copy of the slot table; predicts one result per command.
  class slot_table_scoreboard;
    tsrr_pkg::slot_state_e    slot_st[TASK_SLOTS];
    logic [tsrr_pkg::PcW-1:0] slot_addr[TASK_SLOTS];
    int unsigned     cur;
    sched_result_t   awaited[$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     spawn_ok;
    int unsigned     spawn_full;
    int unsigned     schedules;

    function void clear_table();
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_st[i]   = tsrr_pkg::SLOT_EMPTY;
        slot_addr[i] = '0;
      end
      cur = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_command(tsrr_pkg::cmd_e c, logic [tsrr_pkg::PcW-1:0] entry,
                               logic [tsrr_pkg::PcW-1:0] trap);
      sched_result_t r;
      int unsigned   probe;
      bit            found;
      r = '{status: tsrr_pkg::STATUS_OK, idx: '0, pc: '0};
      if (c == tsrr_pkg::CMD_SPAWN) begin
        found = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!found && slot_st[i] == tsrr_pkg::SLOT_EMPTY) begin
            slot_st[i]   = tsrr_pkg::SLOT_SLEEP;
            slot_addr[i] = entry;
            r.idx        = i[tsrr_pkg::TaskW-1:0];
            found        = 1'b1;
          end
        end
        if (found) spawn_ok++;
        else begin
          r.status = tsrr_pkg::STATUS_FULL;
          spawn_full++;
        end
      end else begin
        // current slot goes to sleep even if it was empty, so the scan always ends
        slot_st[cur]   = tsrr_pkg::SLOT_SLEEP;
        slot_addr[cur] = trap;
        probe = cur;
        for (int n = 0; n < TASK_SLOTS; n++) begin
          probe = (probe + 1) % TASK_SLOTS;
          if (slot_st[probe] == tsrr_pkg::SLOT_SLEEP) break;
        end
        cur            = probe;
        slot_st[probe] = tsrr_pkg::SLOT_RUN;
        r.idx          = probe[tsrr_pkg::TaskW-1:0];
        r.pc           = slot_addr[probe];
        schedules++;
      end
      awaited.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= SHOW_MAX) $display("%0t: MISMATCH %s", $realtime, msg);
    endfunction

    function void check_result(logic status, logic [tsrr_pkg::TaskW-1:0] idx,
                               logic [tsrr_pkg::PcW-1:0] pc);
      sched_result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result with nothing awaited: status %0d index %0d pc %h",
                       status, idx, pc));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (status !== want.status)
        flag($sformatf("status: expected %0d, got %0d", want.status, status));
      if (idx !== want.idx)
        flag($sformatf("task_index: expected %0d, got %0d", want.idx, idx));
      if (pc !== want.pc)
        flag($sformatf("resume_pc: expected %h, got %h", want.pc, pc));
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  tsrr_pkg::cmd_e           cmd_q = tsrr_pkg::CMD_SPAWN;
  logic [tsrr_pkg::PcW-1:0] entry_q = '0;
  logic [tsrr_pkg::PcW-1:0] trap_q = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     status;
  logic [2:0]               task_index;
  logic [tsrr_pkg::PcW-1:0] resume_pc;

  slot_table_scoreboard sb;
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_offs = 0;
  int unsigned stuck_cycles = 0;

  task_slot_round_robin_scheduler #(.TASK_SLOTS(TASK_SLOTS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd_q),
    .entry_pc_i   (entry_q),
    .trap_pc_i    (trap_q),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .task_index_o (task_index),
    .resume_pc_o  (resume_pc)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [tsrr_pkg::PcW-1:0] pick_addr();
    logic [tsrr_pkg::PcW-1:0] a;
    case ($urandom_range(0, 9))
      0: a = '0;
      1: a = '1;
      2: a = 64'd1 << $urandom_range(0, tsrr_pkg::PcW - 1);
      default: a = {$urandom, $urandom};
    endcase
    return a;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(tsrr_pkg::cmd_e c, logic [tsrr_pkg::PcW-1:0] entry,
                          logic [tsrr_pkg::PcW-1:0] trap);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_q    <= c;
    entry_q  <= entry;
    trap_q   <= trap;
    do @(posedge clk_i); while (in_stall);
    sb.note_command(c, entry, trap);
    @(negedge clk_i);
  endtask

  // receiver stall bursts, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
        hold_offs++;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(status, task_index, resume_pc);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STUCK_LIMIT);
      $display("task_slot_round_robin_scheduler test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    sb = new;
    sb.clear_table();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: schedule on an empty current slot, extremes, fill the table, overflow
    send_cmd(tsrr_pkg::CMD_SCHED, pick_addr(), '1);
    send_cmd(tsrr_pkg::CMD_SPAWN, '0, pick_addr());
    send_cmd(tsrr_pkg::CMD_SCHED, pick_addr(), '0);
    send_cmd(tsrr_pkg::CMD_SPAWN, '1, pick_addr());
    send_cmd(tsrr_pkg::CMD_SPAWN, 64'h8000_0000_0000_0001, '1);
    send_cmd(tsrr_pkg::CMD_SCHED, '0, 64'h5555_5555_5555_5555);
    send_cmd(tsrr_pkg::CMD_SCHED, '1, 64'hAAAA_AAAA_AAAA_AAAA);
    repeat (5) send_cmd(tsrr_pkg::CMD_SPAWN, pick_addr(), pick_addr());
    send_cmd(tsrr_pkg::CMD_SPAWN, '1, '1);
    send_cmd(tsrr_pkg::CMD_SPAWN, '0, '0);
    repeat (TASK_SLOTS) send_cmd(tsrr_pkg::CMD_SCHED, pick_addr(), pick_addr());

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      calm = (n >= RANDOM_CMDS - CALM_TAIL) || (n >= 550 && n < 620);
      if (n == HOLD_AT) hold_off_req = 1'b1;
      send_cmd(tsrr_pkg::cmd_e'($urandom_range(0, 1)), pick_addr(), pick_addr());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Commands: %0d spawns took a slot, %0d found the table full, %0d schedules.",
             sb.spawn_ok, sb.spawn_full, sb.schedules);
    $display("Results checked: %0d, mismatches: %0d, long receiver hold-offs: %0d.",
             sb.checked, sb.mismatches, hold_offs);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("task_slot_round_robin_scheduler test passed");
    end else begin
      $display("task_slot_round_robin_scheduler test failed");
    end
    $finish;
  end

endmodule

// ----- task_slot_round_robin_scheduler.f -----
hw/rtl/tsrr_pkg.sv
hw/rtl/tsrr_ram.sv
hw/rtl/tsrr_slot_table.sv
hw/rtl/task_slot_round_robin_scheduler.sv
tb/testbench.sv
